### hdl/spv_pkg.sv
// spv_pkg: shared types, codes and constants for the sample playback voice.
// Used by spv_sample_mem and sample_playback_voice; depends on nothing.
package spv_pkg;

  // sample store geometry
  localparam int unsigned WAVE_WORDS = 16384;
  localparam int unsigned ADDR_W     = $clog2(WAVE_WORDS);
  localparam int unsigned IDX_W      = ADDR_W - 1;    // index within one even/odd bank
  localparam int unsigned BANK_WORDS = WAVE_WORDS / 2;

  // fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IN_ADDR_W = 14;
  localparam int unsigned SAMP_W  = 16;
  localparam int unsigned MIX_W   = 32;
  localparam int unsigned PHASE_W = 32;
  localparam int unsigned VOL_W   = 16;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned FRAMES_W = 15;
  localparam int unsigned FMT_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // register reset values
  localparam logic [VOL_W-1:0]  VOLUME_RST = 16'h0100;
  localparam logic [STEP_W-1:0] STEP_RST   = 24'h01_0000;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_RENDER = 2'd3
  } op_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_MONO8    = 2'd0,
    FMT_MONO16   = 2'd1,
    FMT_STEREO16 = 2'd2,
    FMT_STEREO8  = 2'd3
  } fmt_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 3'd4;

  // write request into the sample store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [SAMP_W-1:0] data;
  } mem_wr_t;

  // read request: both banks at one index
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } mem_rd_t;

  // (p / 256) truncated toward zero, wrapped to 16 bits, sign extended
  function automatic logic [MIX_W-1:0] scale16(input logic signed [MIX_W-1:0] p);
    logic signed [MIX_W-1:0] b;
    b = p + (p[MIX_W-1] ? 32'sd255 : 32'sd0);
    return {{(MIX_W-SAMP_W){b[SAMP_W+7]}}, b[SAMP_W+7:8]};
  endfunction

endpackage

### hdl/spv_sample_mem.sv
// spv_sample_mem: sample store split into even and odd banks, registered read.
// Depends on spv_pkg; both banks are read at one index so a stereo pair comes in one access.
module spv_sample_mem (
  input  logic                        clk_i,
  input  spv_pkg::mem_wr_t            wr_i,
  input  spv_pkg::mem_rd_t            rd_i,
  output logic [spv_pkg::SAMP_W-1:0]  rd_even_o,
  output logic [spv_pkg::SAMP_W-1:0]  rd_odd_o
);
  import spv_pkg::*;

  logic [SAMP_W-1:0] even_mem [BANK_WORDS];
  logic [SAMP_W-1:0] odd_mem  [BANK_WORDS];

  // even bank: entry bit 0 clear
  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.addr[0]) begin
      even_mem[wr_i.addr[ADDR_W-1:1]] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_even_o <= even_mem[rd_i.idx];
    end
  end

  // odd bank: entry bit 0 set
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.addr[0]) begin
      odd_mem[wr_i.addr[ADDR_W-1:1]] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_odd_o <= odd_mem[rd_i.idx];
    end
  end

endmodule

### hdl/sample_playback_voice.sv
// sample_playback_voice: one wave voice, 16.16 phase accumulator, stereo mix adder.
// Depends on spv_pkg and spv_sample_mem.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------------
//   in      | to block  | in_valid_i / in_stall_o  | op, address, write_data, mix_in_l/r
//   out     | from block| out_valid_o / out_stall_i| mix_out_l/r, voice_active, sample_added
//   cfg     | to block  | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; after its request is taken, a result
// passes the store read, multiply, and scale and mix add stages in order. Phase and
// active flag update at the accept edge, so the next request sees them at once. Reset
// clears control state only; the sample store is not cleared. A stall on out backs up
// through the three stages and raises in_stall_o once the read stage is held.
module sample_playback_voice (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [spv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [spv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [spv_pkg::OP_W-1:0]          op_i,
  input  logic [spv_pkg::IN_ADDR_W-1:0]     address_i,
  input  logic signed [spv_pkg::SAMP_W-1:0] write_data_i,
  input  logic signed [spv_pkg::MIX_W-1:0]  mix_in_left_i,
  input  logic signed [spv_pkg::MIX_W-1:0]  mix_in_right_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [spv_pkg::MIX_W-1:0]  mix_out_left_o,
  output logic signed [spv_pkg::MIX_W-1:0]  mix_out_right_o,
  output logic                              voice_active_o,
  output logic                              sample_added_o
);
  import spv_pkg::*;

  // configuration registers
  logic [VOL_W-1:0]    volume_q;
  logic [STEP_W-1:0]   step_q;
  logic                looping_q;
  logic [FRAMES_W-1:0] frames_q;
  fmt_e                fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q  <= VOLUME_RST;
      step_q    <= STEP_RST;
      looping_q <= 1'b0;
      frames_q  <= '0;
      fmt_q     <= FMT_MONO8;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VOLUME:  volume_q  <= cfg_data_i[VOL_W-1:0];
        CFG_STEP:    step_q    <= cfg_data_i[STEP_W-1:0];
        CFG_LOOPING: looping_q <= cfg_data_i[0];
        CFG_FRAMES:  frames_q  <= cfg_data_i[FRAMES_W-1:0];
        CFG_FORMAT:  fmt_q     <= fmt_e'(cfg_data_i[FMT_W-1:0]);
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_v_q, s2_v_q, out_v_q;
  logic s1_adv, s2_adv, in_acc;

  assign s2_adv     = s2_v_q && (!out_v_q || !out_stall_i);
  assign s1_adv     = s1_v_q && (!s2_v_q || s2_adv);
  assign in_stall_o = s1_v_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // voice state
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               active_q, active_d;
  logic [PHASE_W-1:0] end_phase, eff_phase;
  logic [15:0]        frame;
  logic               play, added;
  op_e                op;

  assign op        = op_e'(op_i);
  assign end_phase = {1'b0, frames_q, 16'h0000};
  assign eff_phase = (phase_q >= end_phase && looping_q) ? '0 : phase_q;
  assign frame     = eff_phase[PHASE_W-1:16];
  assign play      = eff_phase < end_phase;

  // next phase and active flag
  always_comb begin
    phase_d  = phase_q;
    active_d = active_q;
    added    = 1'b0;
    case (op)
      OP_START: begin
        phase_d  = '0;
        active_d = 1'b1;
      end
      OP_STOP: begin
        active_d = 1'b0;
      end
      OP_RENDER: begin
        if (active_q) begin
          if (fmt_q == FMT_STEREO8) begin
            active_d = 1'b0;
          end else if (play) begin
            phase_d = eff_phase + PHASE_W'(step_q);
            added   = 1'b1;
          end else begin
            phase_d = eff_phase;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      active_q <= 1'b0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      active_q <= active_d;
    end
  end

  // sample store access
  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [SAMP_W-1:0] rd_even, rd_odd;

  assign mem_wr.en   = in_acc && (op == OP_WRITE);
  assign mem_wr.addr = ADDR_W'(address_i);
  assign mem_wr.data = write_data_i;
  assign mem_rd.en   = in_acc && added;
  assign mem_rd.idx  = (fmt_q == FMT_STEREO16) ? IDX_W'(frame) : IDX_W'(frame >> 1);

  spv_sample_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_i      (mem_rd),
    .rd_even_o (rd_even),
    .rd_odd_o  (rd_odd)
  );

  // stage 1: read in flight
  logic                    s1_added_q, s1_sel_q, s1_active_q;
  logic [MIX_W-1:0]        s1_mix_l_q, s1_mix_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_added_q  <= added;
      s1_sel_q    <= frame[0];
      s1_active_q <= active_d;
      s1_mix_l_q  <= (op == OP_RENDER) ? mix_in_left_i  : '0;
      s1_mix_r_q  <= (op == OP_RENDER) ? mix_in_right_i : '0;
    end
  end

  // stage 1 to 2: pick samples and multiply by volume
  logic [SAMP_W-1:0]        mono_word;
  logic signed [SAMP_W-1:0] samp_l, samp_r;
  logic signed [MIX_W-1:0]  prod_l, prod_r;

  assign mono_word = s1_sel_q ? rd_odd : rd_even;

  always_comb begin
    case (fmt_q)
      FMT_MONO8: begin
        samp_l = {{8{mono_word[7]}}, mono_word[7:0]};
        samp_r = samp_l;
      end
      FMT_STEREO16: begin
        samp_l = rd_even;
        samp_r = rd_odd;
      end
      default: begin
        samp_l = mono_word;
        samp_r = mono_word;
      end
    endcase
  end

  // 16-bit sample times 16-bit gain always fits in 32 signed bits
  assign prod_l = samp_l * $signed({1'b0, volume_q});
  assign prod_r = samp_r * $signed({1'b0, volume_q});

  // stage 2: products
  logic                    s2_added_q, s2_active_q;
  logic [MIX_W-1:0]        s2_mix_l_q, s2_mix_r_q;
  logic signed [MIX_W-1:0] s2_prod_l_q, s2_prod_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s1_adv) begin
      s2_v_q <= 1'b1;
    end else if (s2_adv) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_added_q  <= s1_added_q;
      s2_active_q <= s1_active_q;
      s2_mix_l_q  <= s1_mix_l_q;
      s2_mix_r_q  <= s1_mix_r_q;
      s2_prod_l_q <= prod_l;
      s2_prod_r_q <= prod_r;
    end
  end

  // stage 2 to output: scale (not for 8-bit mono) and add into the mix when a sample was added
  logic [MIX_W-1:0] contrib_l, contrib_r;

  assign contrib_l = (fmt_q == FMT_MONO8) ? s2_prod_l_q : scale16(s2_prod_l_q);
  assign contrib_r = (fmt_q == FMT_MONO8) ? s2_prod_r_q : scale16(s2_prod_r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_adv) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      mix_out_left_o  <= s2_added_q ? s2_mix_l_q + contrib_l : s2_mix_l_q;
      mix_out_right_o <= s2_added_q ? s2_mix_r_q + contrib_r : s2_mix_r_q;
      voice_active_o  <= s2_active_q;
      sample_added_o  <= s2_added_q;
    end
  end

  assign out_valid_o = out_v_q;

  // checks
  a_added_implies_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_added_o |-> voice_active_o)
    else $error("sample added on an inactive voice");

  a_stall_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_v_q |-> !in_stall_o)
    else $error("input stalled with read stage empty");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op == OP_STOP |=> !active_q)
    else $error("stop left voice active");

  a_idle_render_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op == OP_RENDER && !active_q |=> $stable(phase_q))
    else $error("inactive render moved the phase");

endmodule
